// ===== hw/rtl/sqmm_pkg.sv =====
// Shared types and constants for the square matrix multiply block.
// No dependencies; used by square_matrix_multiply and sqmm_checker.
`default_nettype none

package sqmm_pkg;

  localparam int OPC_W  = 2;
  localparam int IDX_W  = 7;
  localparam int ELEM_W = 16;
  localparam int ACC_W  = 32;
  localparam int SIZE_W = 8;

  typedef logic [OPC_W-1:0]  opcode_t;
  typedef logic [IDX_W-1:0]  index_t;
  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [ACC_W-1:0]  acc_t;
  typedef logic [SIZE_W-1:0] size_t;

  localparam opcode_t OPC_LOAD_A = 2'd0;
  localparam opcode_t OPC_LOAD_B = 2'd1;
  localparam opcode_t OPC_QUERY  = 2'd2;
  localparam opcode_t OPC_NONE   = 2'd3;

  localparam size_t SIZE_RESET = 8'd128;

endpackage

`default_nettype wire

// ===== hw/rtl/square_matrix_multiply.sv =====
// Square matrix multiply: two element stores and one shared multiply-accumulate.
// Depends on sqmm_pkg.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_stall   | opcode, row, column, value
//   out_    | output    | out_valid / out_stall | product, row, column
//   cfg_    | input     | cfg_we                | matrix size (8 bits)
//
// A load is taken without stalling the input. A query with n = min(matrix size,
// MAX_DIM) terms stalls the input while its terms pass through the read ports and
// the single multiply-accumulate unit, the multiply and add drain, the block
// leaves the run state and the output register is loaded. With no terms (size
// zero, row or column outside) only the last two of these steps remain.
// Reset is synchronous and clears control only; the stores are not cleared.
// The result waits in the output register; a query ending while it is still
// held waits until it is taken. Loads are taken while a result waits.
`default_nettype none

module square_matrix_multiply #(
  parameter int MAX_DIM = 128
) (
  input  wire                    clk,
  input  wire                    rst_n,

  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire  sqmm_pkg::opcode_t in_opcode,
  input  wire  sqmm_pkg::index_t  in_row,
  input  wire  sqmm_pkg::index_t  in_column,
  input  wire  sqmm_pkg::elem_t   in_value,

  output logic                   out_valid,
  input  wire                    out_stall,
  output sqmm_pkg::acc_t         out_product,
  output sqmm_pkg::index_t       out_row,
  output sqmm_pkg::index_t       out_column,

  input  wire                    cfg_we,
  input  wire  sqmm_pkg::size_t   cfg_wdata
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(MAX_DIM + 1);
  localparam int CMP_W  = (CNT_W > sqmm_pkg::SIZE_W) ? CNT_W : sqmm_pkg::SIZE_W;

  localparam logic [CMP_W-1:0]  MAX_DIM_C  = CMP_W'(MAX_DIM);
  localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(MAX_DIM);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]             state_r;
  sqmm_pkg::size_t        size_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [ADDR_W-1:0]      addr_a_r;
  logic [ADDR_W-1:0]      addr_b_r;
  sqmm_pkg::index_t       q_row_r;
  sqmm_pkg::index_t       q_col_r;
  logic                   s1_vld_r;
  logic                   s2_vld_r;
  sqmm_pkg::elem_t        rd_a_r;
  sqmm_pkg::elem_t        rd_b_r;
  sqmm_pkg::acc_t         prod_r;
  sqmm_pkg::acc_t         acc_r;
  logic                   out_valid_r;
  sqmm_pkg::acc_t         out_product_r;
  sqmm_pkg::index_t       out_row_r;
  sqmm_pkg::index_t       out_col_r;

  sqmm_pkg::elem_t        mem_a [DEPTH];
  sqmm_pkg::elem_t        mem_b [DEPTH];

  logic [CMP_W-1:0]       size_ext;
  logic [CMP_W-1:0]       n_use;
  logic [CMP_W-1:0]       row_ext;
  logic [CMP_W-1:0]       col_ext;
  logic [ADDR_W-1:0]      row_base;
  logic [ADDR_W-1:0]      col_addr;
  logic [ADDR_W-1:0]      wr_addr;
  logic                   in_acc;
  logic                   wr_a;
  logic                   wr_b;
  logic                   start_q;
  logic                   q_inside;
  logic                   issue;
  logic                   out_free;

  always_comb begin
    size_ext = CMP_W'(size_r);
    n_use    = (size_ext < MAX_DIM_C) ? size_ext : MAX_DIM_C;
    row_ext  = CMP_W'(in_row);
    col_ext  = CMP_W'(in_column);
    row_base = ADDR_W'(ADDR_W'(in_row) * ROW_STEP);
    col_addr = ADDR_W'(in_column);
    wr_addr  = ADDR_W'(row_base + col_addr);
    in_acc   = in_valid && !in_stall;
    wr_a     = in_acc && (in_opcode == sqmm_pkg::OPC_LOAD_A)
               && (row_ext < MAX_DIM_C) && (col_ext < MAX_DIM_C);
    wr_b     = in_acc && (in_opcode == sqmm_pkg::OPC_LOAD_B)
               && (row_ext < MAX_DIM_C) && (col_ext < MAX_DIM_C);
    start_q  = in_acc && (in_opcode == sqmm_pkg::OPC_QUERY);
    q_inside = (row_ext < n_use) && (col_ext < n_use);
    issue    = (state_r == ST_RUN) && (cnt_r != '0);
    out_free = !out_valid_r || !out_stall;
  end

  assign in_stall    = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_product = out_product_r;
  assign out_row     = out_row_r;
  assign out_column  = out_col_r;

  // element stores: one write and one registered read each
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[wr_addr] <= in_value;
    end
    if (issue) begin
      rd_a_r <= mem_a[addr_a_r];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[wr_addr] <= in_value;
    end
    if (issue) begin
      rd_b_r <= mem_b[addr_b_r];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      prod_r <= sqmm_pkg::ACC_W'(rd_a_r) * sqmm_pkg::ACC_W'(rd_b_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_r      <= sqmm_pkg::SIZE_RESET;
      cnt_r       <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r;
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (start_q) begin
            state_r  <= ST_RUN;
            cnt_r    <= q_inside ? CNT_W'(n_use) : '0;
            addr_a_r <= row_base;
            addr_b_r <= col_addr;
            q_row_r  <= in_row;
            q_col_r  <= in_column;
            acc_r    <= '0;
          end
        end
        ST_RUN: begin
          if (issue) begin
            cnt_r    <= cnt_r - 1'b1;
            addr_a_r <= addr_a_r + 1'b1;
            addr_b_r <= addr_b_r + ROW_STEP;
          end
          if (s2_vld_r) begin
            acc_r <= acc_r + prod_r;
          end
          if (!issue && !s1_vld_r && !s2_vld_r) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_product_r <= acc_r;
            out_row_r     <= q_row_r;
            out_col_r     <= q_col_r;
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sqmm_checker.sv =====
// Port-level checks for square_matrix_multiply, attached by bind.
// Depends on sqmm_pkg and the top level's port list.
`default_nettype none

module sqmm_props (
  input wire                    clk,
  input wire                    rst_n,
  input wire                    in_valid,
  input wire                    in_stall,
  input wire sqmm_pkg::opcode_t in_opcode,
  input wire                    out_valid,
  input wire                    out_stall,
  input wire sqmm_pkg::acc_t    out_product,
  input wire sqmm_pkg::index_t  out_row,
  input wire sqmm_pkg::index_t  out_column
);

  // a query transaction occupies the block
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_opcode == sqmm_pkg::OPC_QUERY) |=> in_stall)
    else $error("input not stalled after query transaction");

  // a load transaction leaves the input unstalled
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall &&
     (in_opcode == sqmm_pkg::OPC_LOAD_A || in_opcode == sqmm_pkg::OPC_LOAD_B))
    |=> !in_stall)
    else $error("input stalled after load transaction");

  // a result appears only at the end of a query
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a query in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_product) && $stable(out_row) && $stable(out_column)))
    else $error("stalled result changed");

endmodule

bind square_matrix_multiply sqmm_props u_sqmm_props (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_opcode   (in_opcode),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_product (out_product),
  .out_row     (out_row),
  .out_column  (out_column)
);

`default_nettype wire
